>>> rtl/float_to_decimal_ascii_core_macros.svh
// Assertion macros shared by the float-to-decimal ASCII core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FLOAT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define FLOAT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define FDA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fda assertion failed");

// next-cycle implication
`define FDA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fda assertion failed");

`else

`define FDA_ASSERT_IMPL(name, clk, rst, ante, cons)
`define FDA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/fda_pkg.sv
// Shared types and constants of the float-to-decimal ASCII core.
// No dependencies; used by fda_ctrl, fda_datapath and the top level.
package fda_pkg;

   // ASCII codes
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_POINT = 8'h2E;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Number formats
   localparam int INT_BITS  = 31;   // integer part, saturates at 2^31-1
   localparam int FRAC_BITS = 54;   // exact fixed-point fraction width
   localparam int SIG_BITS  = 24;   // significand with hidden bit
   localparam int INT_DIGITS = 10;  // max decimal digits of the integer part

   localparam logic [INT_BITS-1:0] INT_SATURATE = 31'h7FFF_FFFF;
   // floor(x * RECIP_TEN / 2^35) == floor(x / 10) for any 32-bit x
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   // IEEE-754 single exponent landmarks
   localparam logic [7:0] EXP_SPECIAL  = 8'd255;
   localparam logic [7:0] EXP_INT_ONLY = 8'd150;  // no fraction bits left
   localparam logic [7:0] EXP_OVERFLOW = 8'd158;  // magnitude >= 2^31
   localparam logic [7:0] SUBNORM_RS   = 8'd149;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_INT,
      ST_POINT,
      ST_FRAC
   } fda_state_type;

   typedef enum logic [1:0] {
      SEL_SIGN,
      SEL_INT,
      SEL_POINT,
      SEL_FRAC
   } fda_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic        load;
      logic        conv;
      logic        emit;
      fda_sel_type sel;
      logic        last;
   } fda_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic conv_done;
      logic minus;
      logic int_last;
      logic frac_last;
      logic out_free;
   } fda_status_type;

endpackage

>>> rtl/fda_ctrl.sv
// Sequencer of the float-to-decimal ASCII core: accept, integer digit
// conversion, then character emission. Depends on fda_pkg.
module fda_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fda_pkg::fda_status_type status,
   output fda_pkg::fda_cmd_type    cmd
);

   fda_pkg::fda_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.conv  = 1'b0;
      cmd.emit  = 1'b0;
      cmd.sel   = fda_pkg::SEL_SIGN;
      cmd.last  = 1'b0;
      req_stall = (state_ff != fda_pkg::ST_IDLE);
      unique case (state_ff)
         fda_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = fda_pkg::ST_CONV;
            end
         end
         fda_pkg::ST_CONV: begin
            // one decimal digit per cycle, least significant first
            cmd.conv = 1'b1;
            if (status.conv_done) begin
               state_in = status.minus ? fda_pkg::ST_SIGN : fda_pkg::ST_INT;
            end
         end
         fda_pkg::ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = fda_pkg::SEL_SIGN;
               state_in = fda_pkg::ST_INT;
            end
         end
         fda_pkg::ST_INT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = fda_pkg::SEL_INT;
               if (status.int_last) begin
                  state_in = fda_pkg::ST_POINT;
               end
            end
         end
         fda_pkg::ST_POINT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = fda_pkg::SEL_POINT;
               state_in = fda_pkg::ST_FRAC;
            end
         end
         fda_pkg::ST_FRAC: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = fda_pkg::SEL_FRAC;
               cmd.last = status.frac_last;
               if (status.frac_last) begin
                  state_in = fda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = fda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/fda_datapath.sv
// Datapath of the float-to-decimal ASCII core: float decode, divide-by-ten
// digit loop, fraction digit generator and the output register.
// Depends on fda_pkg.
module fda_datapath #(
   parameter int FRACTION_DIGITS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             req_value_bits,
   input  fda_pkg::fda_cmd_type    cmd,
   output fda_pkg::fda_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_text_char,
   output logic                    rsp_last_char,
   output logic [4:0]              rsp_text_length
);

   localparam int FCW = $clog2(FRACTION_DIGITS + 1);
   localparam int IDX_BITS = $clog2(fda_pkg::INT_DIGITS);
   localparam int ND_BITS = $clog2(fda_pkg::INT_DIGITS + 1);
   localparam logic [4:0] FIXED_CHARS = 5'(FRACTION_DIGITS + 1);

   logic                            minus_ff, minus_in;
   logic [fda_pkg::INT_BITS-1:0]    int_ff, int_in;
   logic [fda_pkg::FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [3:0]                      dbuf_ff [fda_pkg::INT_DIGITS];
   logic [3:0]                      dbuf_in [fda_pkg::INT_DIGITS];
   logic [ND_BITS-1:0]              nd_ff, nd_in;
   logic [IDX_BITS-1:0]             eidx_ff, eidx_in;
   logic [FCW-1:0]                  fcnt_ff, fcnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [4:0]                      rsp_len_ff, rsp_len_in;

   logic                            dec_minus;
   logic [fda_pkg::INT_BITS-1:0]    dec_int;
   logic [fda_pkg::FRAC_BITS-1:0]   dec_frac;
   logic [63:0]                     prod;
   logic [fda_pkg::INT_BITS-1:0]    quot;
   logic [fda_pkg::INT_BITS-1:0]    rem;
   logic [fda_pkg::FRAC_BITS+3:0]   fstep;
   logic [4:0]                      text_len;

   // float decode: integer part and exact 54-bit binary fraction
   always_comb begin
      logic                         sgn;
      logic [7:0]                   expo;
      logic [22:0]                  mant;
      logic [fda_pkg::SIG_BITS-1:0] sig;
      logic [fda_pkg::SIG_BITS-1:0] low;
      logic [7:0]                   rs;
      logic [5:0]                   fsh;
      sgn  = req_value_bits[31];
      expo = req_value_bits[30:23];
      mant = req_value_bits[22:0];
      sig  = (expo == 8'd0) ? {1'b0, mant} : {1'b1, mant};
      rs   = (expo == 8'd0) ? fda_pkg::SUBNORM_RS : 8'(fda_pkg::EXP_INT_ONLY - expo);
      low  = sig & ~({fda_pkg::SIG_BITS{1'b1}} << rs);
      fsh  = 6'(7'd54 - 7'(rs));
      dec_int  = '0;
      dec_frac = '0;
      if (expo == fda_pkg::EXP_SPECIAL) begin
         dec_minus = sgn && (mant == 23'd0);
         dec_int   = fda_pkg::INT_SATURATE;
      end else begin
         dec_minus = sgn && ((expo != 8'd0) || (mant != 23'd0));
         if (expo >= fda_pkg::EXP_OVERFLOW) begin
            dec_int = fda_pkg::INT_SATURATE;
         end else if (expo >= fda_pkg::EXP_INT_ONLY) begin
            dec_int = {7'd0, sig} << 3'(expo - fda_pkg::EXP_INT_ONLY);
         end else begin
            dec_int = 31'(sig >> rs);
            if (rs <= 8'd54) begin
               dec_frac = fda_pkg::FRAC_BITS'(low) << fsh;
            end
         end
      end
   end

   // divide by ten through the reciprocal, remainder by shift-add
   always_comb begin
      logic [fda_pkg::INT_BITS-1:0] q10;
      prod  = {32'd0, 1'b0, int_ff} * {32'd0, fda_pkg::RECIP_TEN};
      quot  = 31'(prod >> fda_pkg::RECIP_SHIFT);
      q10   = 31'({quot, 3'b000}) + 31'({quot, 1'b0});
      rem   = int_ff - q10;
   end

   // next fraction digit: multiply the binary fraction by ten
   assign fstep = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);

   assign text_len = 5'(minus_ff) + 5'(nd_ff) + FIXED_CHARS;

   // status to the controller
   assign status.conv_done = (int_ff < 31'd10);
   assign status.minus     = minus_ff;
   assign status.int_last  = (eidx_ff == '0);
   assign status.frac_last = (fcnt_ff == FCW'(FRACTION_DIGITS - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // working registers
   always_comb begin
      minus_in = minus_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      dbuf_in  = dbuf_ff;
      nd_in    = nd_ff;
      eidx_in  = eidx_ff;
      fcnt_in  = fcnt_ff;
      if (cmd.load) begin
         minus_in = dec_minus;
         int_in   = dec_int;
         frac_in  = dec_frac;
         nd_in    = '0;
         fcnt_in  = '0;
      end
      if (cmd.conv) begin
         dbuf_in[IDX_BITS'(nd_ff)] = rem[3:0];
         int_in  = quot;
         nd_in   = nd_ff + 1'b1;
         eidx_in = IDX_BITS'(nd_ff);
      end
      if (cmd.emit && (cmd.sel == fda_pkg::SEL_INT)) begin
         eidx_in = eidx_ff - 1'b1;
      end
      if (cmd.emit && (cmd.sel == fda_pkg::SEL_FRAC)) begin
         frac_in = fstep[fda_pkg::FRAC_BITS-1:0];
         fcnt_in = fcnt_ff + 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         rsp_len_in   = cmd.last ? text_len : 5'd0;
         unique case (cmd.sel)
            fda_pkg::SEL_SIGN:  rsp_char_in = fda_pkg::ASCII_MINUS;
            fda_pkg::SEL_INT:   rsp_char_in = fda_pkg::ASCII_ZERO + {4'd0, dbuf_ff[eidx_ff]};
            fda_pkg::SEL_POINT: rsp_char_in = fda_pkg::ASCII_POINT;
            fda_pkg::SEL_FRAC:  rsp_char_in = fda_pkg::ASCII_ZERO
                                   + {4'd0, fstep[fda_pkg::FRAC_BITS+3:fda_pkg::FRAC_BITS]};
            default:            rsp_char_in = fda_pkg::ASCII_POINT;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      minus_ff    <= minus_in;
      int_ff      <= int_in;
      frac_ff     <= frac_in;
      dbuf_ff     <= dbuf_in;
      nd_ff       <= nd_in;
      eidx_ff     <= eidx_in;
      fcnt_ff     <= fcnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_char   = rsp_char_ff;
   assign rsp_last_char   = rsp_last_ff;
   assign rsp_text_length = rsp_len_ff;

endmodule

>>> rtl/float_to_decimal_ascii_core.sv
// Float-to-decimal ASCII core: takes one IEEE-754 single as raw bits and
// sends its text one character per transfer: an optional '-', the integer
// digits (a lone '0' when the integer part is zero), '.', then exactly
// FRACTION_DIGITS fraction digits, all truncated toward zero. Magnitudes
// of 2^31 and above, infinities and NaN print 2147483647 (NaN unsigned).
// The last character has rsp_last_char set and rsp_text_length holds the
// character count, sign included. One value is handled at a time: first
// its integer digits (1..10) are made, one divide-by-ten step per cycle,
// then its text is sent at one character per cycle through the output
// register while that register is not held by rsp_stall. req_stall is
// high from accept until the last character is loaded into the output
// register.
// Depends on fda_pkg, fda_ctrl, fda_datapath and the macros header.
`include "float_to_decimal_ascii_core_macros.svh"

module float_to_decimal_ascii_core #(
   parameter int FRACTION_DIGITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last_char,
   output logic [4:0]  rsp_text_length
);

   fda_pkg::fda_cmd_type    cmd;
   fda_pkg::fda_status_type status;

   // sequencer
   fda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // decode, digit generation and output register
   fda_datapath #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_value_bits  (req_value_bits),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_text_length (rsp_text_length)
   );

   // busy right after a transfer in
   `FDA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // length only on the final character
   `FDA_ASSERT_IMPL(a_len_only_last, clock, reset, rsp_valid && !rsp_last_char, rsp_text_length == 5'd0)
   // text always ends in a fraction digit
   `FDA_ASSERT_IMPL(a_last_is_digit, clock, reset, rsp_valid && rsp_last_char, (rsp_text_char >= fda_pkg::ASCII_ZERO) && (rsp_text_char <= fda_pkg::ASCII_NINE))

endmodule
